// File: src/lrukv_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lrukv_pkg;

  localparam int ENTRIES_DEF = 8;
  localparam int KEY_W       = 64;
  localparam int VAL_W       = 32;

  typedef enum logic {
    REQ_GET = 1'b0,
    REQ_PUT = 1'b1
  } req_type_t;

  // Lookup outcome for the request held in the input stage.
  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value;
  } lookup_t;

endpackage

// File: src/lru_key_value_cache_unit.sv
// Top level of the fully associative LRU key-value cache.
// A get word shows on the output after it is held in the input register for
// the lookup and then in the result register; puts produce no output word.
// Throughput: one request word per cycle unless a get waits on a busy result
// register; match and rank update in the entry table are combinational.
// Reset (rst_n, synchronous, active low) clears valid marks, ranks and both stages.
module lru_key_value_cache_unit import lrukv_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_req_type,
  input  logic [KEY_W-1:0] in_key,
  input  logic [VAL_W-1:0] in_write_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_found,
  output logic [VAL_W-1:0] out_read_value
);

  // Input register: holds one request word while it is looked up.
  logic             stg_vld_r;
  logic             stg_put_r;
  logic [KEY_W-1:0] stg_key_r;
  logic [VAL_W-1:0] stg_wval_r;

  // Result register: decouples the output side from the lookup.
  logic             out_vld_r;
  logic             out_found_r;
  logic [VAL_W-1:0] out_value_r;

  lookup_t lkp;
  logic    out_free, fire, in_fire;

  // A put always retires; a get retires only when the result register
  // can take its word in the same cycle.
  assign out_free = !out_vld_r || out_ready;
  assign fire     = stg_vld_r && (stg_put_r || out_free);
  assign in_ready = !stg_vld_r || fire;
  assign in_fire  = in_valid && in_ready;

  lrukv_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_fire (fire),
    .req_put  (stg_put_r),
    .req_key  (stg_key_r),
    .req_wval (stg_wval_r),
    .lkp      (lkp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        stg_vld_r <= in_valid;
      end
      if (fire && !stg_put_r) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_put_r  <= (in_req_type == REQ_PUT);
      stg_key_r  <= in_key;
      stg_wval_r <= in_write_value;
    end
    if (fire && !stg_put_r) begin
      out_found_r <= lkp.hit;
      out_value_r <= lkp.value;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_found      = out_found_r;
  assign out_read_value = out_value_r;

endmodule

// File: src/lrukv_table.sv
// Entry storage, parallel key match and recency rank update of the cache.
module lrukv_table import lrukv_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_fire,
  input  logic             req_put,
  input  logic [KEY_W-1:0] req_key,
  input  logic [VAL_W-1:0] req_wval,
  output lookup_t          lkp
);

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [RANK_W-1:0] OLDEST = RANK_W'(ENTRIES - 1);

  logic [ENTRIES-1:0]             valid_r, valid_nxt;
  logic [ENTRIES-1:0][RANK_W-1:0] rank_r, rank_nxt;
  logic [KEY_W-1:0]               key_r [ENTRIES];
  logic [VAL_W-1:0]               val_r [ENTRIES];

  logic [ENTRIES-1:0] hit_vec, free_vec, free_sel, old_vec, old_sel, tgt_vec, wr_vec;
  logic [RANK_W-1:0]  hit_rank;
  logic [VAL_W-1:0]   hit_val;
  logic               hit, full, update;

  always_comb begin
    hit_rank = '0;
    hit_val  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (key_r[i] == req_key);
      old_vec[i] = (rank_r[i] == OLDEST);
      // Valid keys are unique, so at most one entry matches.
      hit_rank = hit_rank | (rank_r[i] & {RANK_W{hit_vec[i]}});
      hit_val  = hit_val  | (val_r[i]  & {VAL_W{hit_vec[i]}});
    end
    hit      = |hit_vec;
    full     = &valid_r;
    free_vec = ~valid_r;
    // Isolate the lowest set bit: lowest free entry, lowest oldest entry.
    free_sel = free_vec & ~(free_vec - ENTRIES'(1));
    old_sel  = old_vec & ~(old_vec - ENTRIES'(1));
    tgt_vec  = hit ? hit_vec : (full ? old_sel : free_sel);
    update   = req_fire && (hit || req_put);
    wr_vec   = (req_fire && req_put) ? tgt_vec : '0;
  end

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    if (update) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (tgt_vec[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (!hit || (rank_r[i] < hit_rank))) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
      end
      valid_nxt = valid_r | wr_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_vec[i]) begin
        key_r[i] <= req_key;
        val_r[i] <= req_wval;
      end
    end
  end

  assign lkp.hit   = hit;
  assign lkp.value = hit_val;

endmodule
